[rtl/core/lsr_pkg.sv]
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants of the literal substring replacer
// Holds the configuration register indexes, the job descriptor that travels
// from the front end to the back end, and the result item layout.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CfgSearchPattern = 2'd0;
  localparam logic [1:0] CfgSearchLength  = 2'd1;
  localparam logic [1:0] CfgReplaceText   = 2'd2;
  localparam logic [1:0] CfgReplaceLength = 2'd3;

  localparam int unsigned CfgDataWidth = 64;
  localparam int unsigned LenWidth     = 4;
  localparam int unsigned ProgWidth    = 3;
  localparam int unsigned MaxResults   = 8;

  // One job: held search bytes to flush, then a middle segment (the
  // replacement or the literal input byte), then a final flush on the last
  // byte of a string. The result count is capped at MaxResults.
  typedef struct packed {
    logic [2:0] a_cnt;     // leading flush of search bytes
    logic [3:0] b_len;     // middle segment length
    logic       b_repl;    // middle segment is the replacement text
    logic [2:0] c_cnt;     // trailing flush of search bytes
    logic [7:0] lit;       // input byte for a literal middle segment
    logic [2:0] total_m1;  // number of results minus one
    logic       has;       // at least one data byte, else one marker
    logic       last;      // job ends a string
  } lsr_desc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
  } lsr_item_t;

endpackage

`default_nettype wire

[rtl/core/lsr_fifo.sv]
// ----------------------------------------------------------------------------
// lsr_fifo: two-entry register queue
// Accepts a write while not full and presents the oldest entry while not
// empty. Used between the front and back ends and at the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lsr_front.sv]
// ----------------------------------------------------------------------------
// lsr_front: match tracker and job classifier
// Compares each accepted byte against the search string, keeps the partial
// match length, and turns the byte into a job descriptor for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_front
  import lsr_pkg::*;
#(
  parameter int unsigned MaxSearch = 8
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [7:0]                text_byte_i,
  input  wire logic                      in_last_i,
  input  wire logic                      clear_i,
  input  wire logic [MaxSearch-1:0][7:0] search_pat_i,
  input  wire logic [LenWidth-1:0]       search_len_i,
  input  wire logic [LenWidth-1:0]       replace_len_i,
  output lsr_desc_t                      desc_o
);

  logic [ProgWidth-1:0] prog_q, prog_d;
  logic [ProgWidth-1:0] j0, jm, jn;
  logic [LenWidth-1:0]  j1;
  logic                 mis, hit, active;
  logic [4:0]           sum;

  function automatic logic [7:0] pick_search(input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < MaxSearch; i++) begin
      if (idx == 3'(i)) begin
        r = search_pat_i[i];
      end
    end
    return r;
  endfunction

  always_comb begin
    active = (search_len_i != '0);
    j0 = (active && ({1'b0, prog_q} < search_len_i)) ? prog_q : '0;
    mis = (text_byte_i != pick_search(j0));
    hit = mis ? (text_byte_i == pick_search(3'd0)) : 1'b1;
    jm = mis ? '0 : j0;
    j1 = {1'b0, jm} + 4'd1;

    desc_o        = '0;
    desc_o.lit    = text_byte_i;
    desc_o.last   = in_last_i;
    desc_o.a_cnt  = (active && mis) ? j0 : '0;
    jn            = '0;

    if (!active) begin
      desc_o.b_len = 4'd1;
    end else if (hit) begin
      if (j1 == search_len_i) begin
        desc_o.b_len  = replace_len_i;
        desc_o.b_repl = 1'b1;
      end else begin
        jn = j1[2:0];
      end
    end else begin
      desc_o.b_len = 4'd1;
    end

    if (active && in_last_i) begin
      desc_o.c_cnt = jn;
      jn = '0;
    end

    sum = {2'b00, desc_o.a_cnt} + {1'b0, desc_o.b_len} + {2'b00, desc_o.c_cnt};
    desc_o.has = (sum != 5'd0);
    if (!desc_o.has) begin
      desc_o.total_m1 = 3'd0;
    end else if (sum >= 5'(MaxResults)) begin
      desc_o.total_m1 = 3'(MaxResults - 1);
    end else begin
      desc_o.total_m1 = 3'(sum - 5'd1);
    end

    if (clear_i) begin
      prog_d = '0;
    end else if (accept_i) begin
      prog_d = jn;
    end else begin
      prog_d = prog_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
    end else begin
      prog_q <= prog_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lsr_back.sv]
// ----------------------------------------------------------------------------
// lsr_back: result sequencer
// Walks the head job descriptor one result per cycle when out_ready_i is set,
// selecting flushed search bytes, replacement bytes or the literal byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_back
  import lsr_pkg::*;
#(
  parameter int unsigned MaxSearch  = 8,
  parameter int unsigned MaxReplace = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lsr_desc_t                  desc_i,
  input  wire logic                       desc_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [MaxSearch-1:0][7:0]  search_pat_i,
  input  wire logic [MaxReplace-1:0][7:0] replace_txt_i,
  output logic                            desc_pop_o,
  output logic                            emit_o,
  output lsr_item_t                       item_o
);

  logic [2:0] k_q, k_d;
  logic [4:0] kk, aa, ab;
  logic       done;

  function automatic logic [7:0] pick_search(input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < MaxSearch; i++) begin
      if (idx == 3'(i)) begin
        r = search_pat_i[i];
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_replace(input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < MaxReplace; i++) begin
      if (idx == 3'(i)) begin
        r = replace_txt_i[i];
      end
    end
    return r;
  endfunction

  always_comb begin
    kk = {2'b00, k_q};
    aa = {2'b00, desc_i.a_cnt};
    ab = aa + {1'b0, desc_i.b_len};

    if (!desc_i.has) begin
      item_o.out_byte = 8'h00;
    end else if (kk < aa) begin
      item_o.out_byte = pick_search(k_q);
    end else if (kk < ab) begin
      item_o.out_byte = desc_i.b_repl ? pick_replace(3'(kk - aa)) : desc_i.lit;
    end else begin
      item_o.out_byte = pick_search(3'(kk - ab));
    end

    done            = (k_q == desc_i.total_m1);
    item_o.has_byte = desc_i.has;
    item_o.out_last = desc_i.last && done;
    emit_o          = desc_valid_i && out_ready_i;
    desc_pop_o      = emit_o && done;

    if (emit_o) begin
      k_d = done ? 3'd0 : k_q + 3'd1;
    end else begin
      k_d = k_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 3'd0;
    end else begin
      k_q <= k_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/literal_substring_replacer_core.sv]
// ----------------------------------------------------------------------------
// literal_substring_replacer_core: streaming literal substring replacement
// Rewrites a byte stream, replacing non-overlapping occurrences of a
// configured search string with a configured replacement string.
// ----------------------------------------------------------------------------
// Usage. Text bytes enter on a queue-style port: a transfer happens on a
// rising edge with push high and full low. Results leave the same way: the
// oldest result is on out_byte_o/has_byte_o/out_last_o while empty is low,
// and a transfer happens on an edge with pop high. Each input byte yields one
// to eight results; a byte that yields no data gives one marker result with
// has_byte_o low. out_last_o marks the final result of a string.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; writing the search pattern or length drops a partial match.
// An input reaches its first result through the job and result queues. The
// front end classifies one byte per cycle; the back end emits one result per
// cycle, so a byte with more than one result holds the back end and full
// rises once the two-entry job queue fills. Throughput is one byte per cycle
// when each byte yields one result. When the receiver stops popping, the
// two-entry result queue fills and the back end and then the input stall.
// Reset empties both queues and zeroes the match state and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_substring_replacer_core
  import lsr_pkg::*;
#(
  parameter int unsigned MAX_SEARCH_BYTES  = 8,
  parameter int unsigned MAX_REPLACE_BYTES = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Text input queue.
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [7:0]              text_byte_i,
  input  wire logic                    in_last_i,
  // Result queue.
  output logic                         empty,
  input  wire logic                    pop,
  output logic [7:0]                   out_byte_o,
  output logic                         has_byte_o,
  output logic                         out_last_o,
  // Configuration write port.
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  // Configuration registers. Lengths are stored already clamped to the
  // supported maxima, which is all the datapath ever needs.
  logic [MAX_SEARCH_BYTES-1:0][7:0]  search_pat_q;
  logic [MAX_REPLACE_BYTES-1:0][7:0] replace_txt_q;
  logic [LenWidth-1:0]               search_len_q, search_len_d;
  logic [LenWidth-1:0]               replace_len_q, replace_len_d;
  logic                              cfg_clear;

  lsr_desc_t desc_in, desc_out;
  logic      in_accept;
  logic      desc_empty, desc_pop;
  logic      ofifo_full, emit;
  lsr_item_t item_in, item_out;

  assign in_accept = push && !full;

  // A write to either search register restarts matching.
  assign cfg_clear = cfg_we_i &&
                     ((cfg_idx_i == CfgSearchPattern) || (cfg_idx_i == CfgSearchLength));

  always_comb begin
    search_len_d = (cfg_data_i[LenWidth-1:0] > LenWidth'(MAX_SEARCH_BYTES)) ?
                   LenWidth'(MAX_SEARCH_BYTES) : cfg_data_i[LenWidth-1:0];
    replace_len_d = (cfg_data_i[LenWidth-1:0] > LenWidth'(MAX_REPLACE_BYTES)) ?
                    LenWidth'(MAX_REPLACE_BYTES) : cfg_data_i[LenWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_pat_q  <= '0;
      replace_txt_q <= '0;
      search_len_q  <= '0;
      replace_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSearchPattern: search_pat_q  <= cfg_data_i[MAX_SEARCH_BYTES*8-1:0];
        CfgSearchLength:  search_len_q  <= search_len_d;
        CfgReplaceText:   replace_txt_q <= cfg_data_i[MAX_REPLACE_BYTES*8-1:0];
        CfgReplaceLength: replace_len_q <= replace_len_d;
        default: begin
        end
      endcase
    end
  end

  // Front end: one byte per cycle unless full, updates the partial match length.
  lsr_front #(
    .MaxSearch(MAX_SEARCH_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .text_byte_i  (text_byte_i),
    .in_last_i    (in_last_i),
    .clear_i      (cfg_clear),
    .search_pat_i (search_pat_q),
    .search_len_i (search_len_q),
    .replace_len_i(replace_len_q),
    .desc_o       (desc_in)
  );

  // Job queue between the front and back ends; its full flag is the input
  // backpressure.
  lsr_fifo #(
    .Width($bits(lsr_desc_t))
  ) u_desc_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (desc_in),
    .full_o (full),
    .pop_i  (desc_pop),
    .data_o (desc_out),
    .empty_o(desc_empty)
  );

  // Back end: one result per cycle from the head job unless ofifo_full is set.
  lsr_back #(
    .MaxSearch (MAX_SEARCH_BYTES),
    .MaxReplace(MAX_REPLACE_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc_out),
    .desc_valid_i (!desc_empty),
    .out_ready_i  (!ofifo_full),
    .search_pat_i (search_pat_q),
    .replace_txt_i(replace_txt_q),
    .desc_pop_o   (desc_pop),
    .emit_o       (emit),
    .item_o       (item_in)
  );

  // Result queue, which decouples the back end from the receiver.
  lsr_fifo #(
    .Width($bits(lsr_item_t))
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .data_i (item_in),
    .full_o (ofifo_full),
    .pop_i  (pop),
    .data_o (item_out),
    .empty_o(empty)
  );

  assign out_byte_o = item_out.out_byte;
  assign has_byte_o = item_out.has_byte;
  assign out_last_o = item_out.out_last;

`ifndef ASSERT_OFF
  // A marker result never carries a data byte value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_byte_o) |-> (out_byte_o == 8'h00))
    else $error("marker result with nonzero byte");

  // With an empty search string every byte is one literal result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (search_len_q == '0)) |->
      (desc_in.has && (desc_in.total_m1 == 3'd0) && (desc_in.lit == text_byte_i)))
    else $error("pass-through job is not a single literal");

  // The back end only emits while the result queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!ofifo_full && !desc_empty))
    else $error("result emitted without room or job");
`endif

endmodule

`default_nettype wire
